FILE: rtl/dct_pkg.sv
`default_nettype none

package dct_pkg;

    // Block size the design is built for unless the top level says otherwise
    localparam int DIM_DEFAULT = 8;

    // Fixed field widths of the channels
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 13;
    localparam int INDEX_W = 6;

    // Cosine table in Q40; sum of two entries needs one bit more
    localparam int COS_FRAC = 40;
    localparam int COS_W    = COS_FRAC + 2;
    localparam int SUM_W    = COS_W + 1;

    // Basis entry: trunc(128 * (cos a + cos b)), range -256..256
    localparam int BASIS_SHIFT = COS_FRAC - 7;
    // An entry within 2^-30 below an integer counts as that integer
    localparam int SNAP_SHIFT  = BASIS_SHIFT - 30;
    localparam int BASIS_W     = 10;

    // Column scale 256*c(u)*c(v) and final shift
    localparam int SCALE_W   = 8;
    localparam int OUT_SHIFT = 16;

    localparam real PI = 4.0 * $atan(1.0);

    // Control word that travels down the MAC pipeline with each product
    typedef struct packed {
        logic               valid;
        logic               first;       // first product of a coefficient
        logic               last;        // last product of a coefficient
        logic               u_zero;
        logic               v_zero;
        logic               final_coef;  // coefficient closes the block
        logic [INDEX_W-1:0] index;
    } dct_ctrl_t;

    // Status from the datapath back to the sequencer
    typedef struct packed {
        logic advance;     // pipeline moves this cycle
        logic block_done;  // final coefficient enters the output register
    } dct_stat_t;

    // cos(m * step) in Q40, built from the first quadrant with mirrored signs
    function automatic logic signed [COS_W-1:0] dct_cos(input int dim, input real step,
                                                        input int m);
        int     t;
        logic   neg;
        real    r;
        longint q;
        if (m <= dim) begin
            t   = m;
            neg = 1'b0;
        end
        else if (m <= 2 * dim) begin
            t   = 2 * dim - m;
            neg = 1'b1;
        end
        else if (m <= 3 * dim) begin
            t   = m - 2 * dim;
            neg = 1'b1;
        end
        else begin
            t   = 4 * dim - m;
            neg = 1'b0;
        end
        r = $cos(step * real'(t));
        q = longint'(r * (2.0 ** COS_FRAC));
        if (neg) begin
            q = -q;
        end
        return COS_W'(q);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dct_if.sv
`default_nettype none

interface dct_pix_if import dct_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface dct_coef_if import dct_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] coefficient;
    logic [INDEX_W-1:0]       coef_index;
    logic                     last_coef;

    modport source (output valid, output coefficient, output coef_index, output last_coef,
                    input ready);
    modport sink   (input valid, input coefficient, input coef_index, input last_coef,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/dct_ram.sv
`default_nettype none

module dct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dct_seq.sv
`default_nettype none

module dct_seq import dct_pkg::*; #(
    parameter int BLOCK_DIM = DIM_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    dct_pix_if.sink                                pixels,
    input  wire dct_stat_t                         stat,
    output      dct_ctrl_t                         ctrl,
    output      logic [$clog2(4*BLOCK_DIM)-1:0]    x_pos,
    output      logic [$clog2(4*BLOCK_DIM)-1:0]    y_pos,
    output      logic                              wr_en,
    output      logic [$clog2(BLOCK_DIM*BLOCK_DIM)-1:0] wr_addr,
    output      logic [$clog2(BLOCK_DIM*BLOCK_DIM)-1:0] rd_addr
);

    localparam int NPIX  = BLOCK_DIM * BLOCK_DIM;
    localparam int NANG  = 4 * BLOCK_DIM;
    localparam int IDX_W = $clog2(NPIX);
    localparam int UW    = $clog2(BLOCK_DIM);
    localparam int XW    = $clog2(NANG);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NPIX - 1);
    localparam logic [UW-1:0]    DIM_LAST = UW'(BLOCK_DIM - 1);
    localparam logic [XW:0]      ANG_MOD  = (XW + 1)'(NANG);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } dct_state_t;

    dct_state_t       state_reg, state_next;
    logic [IDX_W-1:0] lc_reg, lc_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [UW-1:0]    u_reg, u_next, v_reg, v_next, k_reg, k_next, l_reg, l_next;
    logic [XW-1:0]    x_reg, x_next, y_reg, y_next;
    logic             accept;

    // (a + 2h) mod 4N for a below 4N and h below N
    function automatic logic [XW-1:0] mod_add(input logic [XW-1:0] a, input logic [UW-1:0] h);
        logic [XW:0] s;
        s = (XW + 1)'(a) + (XW + 1)'({h, 1'b0});
        if (s >= ANG_MOD)
        begin
            s = s - ANG_MOD;
        end
        return s[XW-1:0];
    endfunction

    assign pixels.ready = (state_reg == ST_LOAD);
    assign accept       = pixels.valid && pixels.ready;
    assign wr_en        = accept;
    assign wr_addr      = lc_reg;
    assign rd_addr      = j_reg;
    assign x_pos        = x_reg;
    assign y_pos        = y_reg;

    always_comb
    begin
        ctrl.valid      = (state_reg == ST_RUN);
        ctrl.first      = (j_reg == '0);
        ctrl.last       = (j_reg == IDX_LAST);
        ctrl.u_zero     = (u_reg == '0);
        ctrl.v_zero     = (v_reg == '0);
        ctrl.final_coef = (i_reg == IDX_LAST);
        ctrl.index      = INDEX_W'(i_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        lc_next    = lc_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        k_next     = k_reg;
        l_next     = l_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (lc_reg == IDX_LAST)
                    begin
                        lc_next    = '0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        lc_next = lc_reg + 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                if (stat.advance)
                begin
                    j_next = (j_reg == IDX_LAST) ? '0 : j_reg + 1'b1;
                    if (l_reg != DIM_LAST)
                    begin
                        l_next = l_reg + 1'b1;
                        y_next = mod_add(y_reg, v_reg);
                    end
                    else if (k_reg != DIM_LAST)
                    begin
                        l_next = '0;
                        k_next = k_reg + 1'b1;
                        x_next = mod_add(x_reg, u_reg);
                        y_next = XW'(v_reg);
                    end
                    else
                    begin
                        // coefficient done: step to the next (u, v)
                        l_next = '0;
                        k_next = '0;
                        i_next = (i_reg == IDX_LAST) ? '0 : i_reg + 1'b1;
                        if (v_reg != DIM_LAST)
                        begin
                            v_next = v_reg + 1'b1;
                            y_next = XW'(v_reg) + 1'b1;
                            x_next = XW'(u_reg);
                        end
                        else
                        begin
                            v_next = '0;
                            y_next = '0;
                            if (u_reg != DIM_LAST)
                            begin
                                u_next = u_reg + 1'b1;
                                x_next = XW'(u_reg) + 1'b1;
                            end
                            else
                            begin
                                u_next = '0;
                                x_next = '0;
                            end
                        end
                        if (i_reg == IDX_LAST)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (stat.block_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            lc_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            u_reg     <= '0;
            v_reg     <= '0;
            k_reg     <= '0;
            l_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lc_reg    <= lc_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            u_reg     <= u_next;
            v_reg     <= v_next;
            k_reg     <= k_next;
            l_reg     <= l_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dct_mac.sv
`default_nettype none

module dct_mac import dct_pkg::*; #(
    parameter int BLOCK_DIM = DIM_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dct_ctrl_t                      ctrl,
    input  wire logic [$clog2(4*BLOCK_DIM)-1:0] x_pos,
    input  wire logic [$clog2(4*BLOCK_DIM)-1:0] y_pos,
    input  wire logic [PIX_W-1:0]               pix_data,
    output      dct_stat_t                      stat,
    dct_coef_if.source                          coefs
);

    localparam int  NPIX   = BLOCK_DIM * BLOCK_DIM;
    localparam int  NANG   = 4 * BLOCK_DIM;
    localparam int  XW     = $clog2(NANG);
    localparam real ANG_STEP = PI / (2.0 * BLOCK_DIM);
    localparam int  PROD_W = PIX_W + 1 + BASIS_W;
    localparam int  ACC_W  = $clog2(NPIX * 255 * 256) + 2;
    localparam int  SCL_W  = ACC_W + SCALE_W + 1;
    localparam int  SH_W   = SCL_W - OUT_SHIFT;

    localparam logic [SCALE_W-1:0] SCALE_DC   = SCALE_W'(256 / BLOCK_DIM);
    localparam logic [SCALE_W-1:0] SCALE_EDGE = SCALE_W'(362 / BLOCK_DIM);
    localparam logic [SCALE_W-1:0] SCALE_AC   = SCALE_W'(512 / BLOCK_DIM);
    localparam logic [XW:0]        ANG_MOD    = (XW + 1)'(NANG);
    localparam logic [SUM_W-1:0]   SNAP       = SUM_W'(1) << SNAP_SHIFT;
    localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((1 << (COEF_W - 1)) - 1);
    localparam logic signed [SH_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [COS_W-1:0] cos_tab [NANG];

    for (genvar m = 0; m < NANG; m++)
    begin : g_cos
        assign cos_tab[m] = dct_cos(BLOCK_DIM, ANG_STEP, m);
    end

    logic                       adv;
    logic [XW:0]                ang_sum;
    logic [XW-1:0]              ang_a, ang_b;
    logic [SUM_W-1:0]           mag;
    logic [SUM_W-1:0]           rnd;
    logic [BASIS_W-1:0]         qmag;
    logic [SCALE_W-1:0]         scale;
    logic signed [SH_W-1:0]     shifted;
    logic signed [COEF_W-1:0]   sat;
    dct_ctrl_t                  c4_in;

    dct_ctrl_t                  c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic signed [SUM_W-1:0]    sum1_reg;
    logic signed [BASIS_W-1:0]  basis2_reg;
    logic [PIX_W-1:0]           pix2_reg;
    logic signed [PROD_W-1:0]   prod3_reg;
    logic signed [ACC_W-1:0]    acc4_reg;
    logic signed [SCL_W-1:0]    scl5_reg;
    logic                       out_vld_reg;
    logic signed [COEF_W-1:0]   out_coef_reg;
    logic [INDEX_W-1:0]         out_idx_reg;
    logic                       out_last_reg;

    // freeze the whole pipeline while a finished coefficient is held
    assign adv             = !(out_vld_reg && !coefs.ready);
    assign stat.advance    = adv;
    assign stat.block_done = adv && c5_reg.valid && c5_reg.final_coef;

    // angle pair for cos(x+y) + cos(x-y)
    always_comb
    begin
        ang_sum = (XW + 1)'(x_pos) + (XW + 1)'(y_pos);
        if (ang_sum >= ANG_MOD)
        begin
            ang_sum = ang_sum - ANG_MOD;
        end
        ang_a = ang_sum[XW-1:0];
        ang_b = (x_pos >= y_pos) ? x_pos - y_pos : y_pos - x_pos;
    end

    // truncate toward zero with the snap margin
    always_comb
    begin
        mag  = sum1_reg[SUM_W-1] ? SUM_W'(-sum1_reg) : SUM_W'(sum1_reg);
        rnd  = (mag + SNAP) >> BASIS_SHIFT;
        qmag = rnd[BASIS_W-1:0];
    end

    // only the last product of a coefficient moves on past the accumulator
    always_comb
    begin
        c4_in       = c3_reg;
        c4_in.valid = c3_reg.valid && c3_reg.last;
    end

    always_comb
    begin
        case ({c4_reg.u_zero, c4_reg.v_zero})
            2'b11:   scale = SCALE_DC;
            2'b10,
            2'b01:   scale = SCALE_EDGE;
            default: scale = SCALE_AC;
        endcase
    end

    always_comb
    begin
        shifted = SH_W'(scl5_reg >>> OUT_SHIFT);
        if (shifted > SAT_HI)
        begin
            sat = SAT_HI[COEF_W-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            sat = SAT_LO[COEF_W-1:0];
        end
        else
        begin
            sat = shifted[COEF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg      <= '0;
            c2_reg      <= '0;
            c3_reg      <= '0;
            c4_reg      <= '0;
            c5_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                c1_reg <= ctrl;
                c2_reg <= c1_reg;
                c3_reg <= c2_reg;
                c4_reg <= c4_in;
                c5_reg <= c4_reg;
            end
            if (adv && c5_reg.valid)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (coefs.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum1_reg   <= SUM_W'(cos_tab[ang_a]) + SUM_W'(cos_tab[ang_b]);
            basis2_reg <= sum1_reg[SUM_W-1] ? -$signed(qmag) : $signed(qmag);
            pix2_reg   <= pix_data;
            prod3_reg  <= PROD_W'($signed({1'b0, pix2_reg})) * PROD_W'(basis2_reg);
            if (c3_reg.valid)
            begin
                acc4_reg <= c3_reg.first ? ACC_W'(prod3_reg) : acc4_reg + ACC_W'(prod3_reg);
            end
            scl5_reg <= SCL_W'(acc4_reg) * SCL_W'($signed({1'b0, scale}));
            if (c5_reg.valid)
            begin
                out_coef_reg <= sat;
                out_idx_reg  <= c5_reg.index;
                out_last_reg <= c5_reg.final_coef;
            end
        end
    end

    assign coefs.valid       = out_vld_reg;
    assign coefs.coefficient = out_coef_reg;
    assign coefs.coef_index  = out_idx_reg;
    assign coefs.last_coef   = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/forward_dct_8x8.sv
`default_nettype none

// Channel  | Dir | Word                                  | Handshake
// ---------+-----+---------------------------------------+------------------
// pixels   | in  | pixel[7:0], raster order              | valid/ready
// coefs    | out | coefficient[12:0], coef_index[5:0],   | valid/ready
//          |     | last_coef                             |
//
// Load takes one pixel word a cycle; ready drops after the last pixel of a block.
// The single MAC unit issues N^4 products (4096 for 8x8), one a cycle while no
// coefficient is held; ready stays low until the final coefficient is registered.
// One coefficient per N*N products, each via sum, basis, product, acc and scale.
// Reset clears the sequencer and pipeline valids; the pixel store is not cleared.
// A held coefficient freezes the MAC pipeline; the next block loads behind the last.

module forward_dct_8x8 import dct_pkg::*; #(
    parameter int BLOCK_DIM = DIM_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dct_pix_if.sink    pixels,
    dct_coef_if.source coefs
);

    localparam int NPIX  = BLOCK_DIM * BLOCK_DIM;
    localparam int IDX_W = $clog2(NPIX);
    localparam int XW    = $clog2(4 * BLOCK_DIM);

    dct_ctrl_t        ctrl;
    dct_stat_t        stat;
    logic [XW-1:0]    x_pos, y_pos;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [PIX_W-1:0] pix_data;

    // Sequencer: load counter, (u, v, k, l) walk and angle tracking
    dct_seq #(.BLOCK_DIM(BLOCK_DIM)) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels),
        .stat    (stat),
        .ctrl    (ctrl),
        .x_pos   (x_pos),
        .y_pos   (y_pos),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr)
    );

    // Pixel store; hold the read word while the pipeline is frozen
    dct_ram #(.WIDTH(PIX_W), .DEPTH(NPIX)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pixels.pixel),
        .rd_en   (stat.advance),
        .rd_addr (rd_addr),
        .rd_data (pix_data)
    );

    // Basis lookup, multiply-accumulate, scale, shift and output register
    dct_mac #(.BLOCK_DIM(BLOCK_DIM)) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .x_pos    (x_pos),
        .y_pos    (y_pos),
        .pix_data (pix_data),
        .stat     (stat),
        .coefs    (coefs)
    );

endmodule

`default_nettype wire

FILE: rtl/dct_chk.sv
`default_nettype none

module dct_chk import dct_pkg::*; #(
    parameter int BLOCK_DIM = DIM_DEFAULT
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               pix_valid,
    input wire logic               pix_ready,
    input wire logic               coef_valid,
    input wire logic               coef_ready,
    input wire logic [COEF_W-1:0]  coefficient,
    input wire logic [INDEX_W-1:0] coef_index,
    input wire logic               last_coef
);

    localparam logic [INDEX_W-1:0] IDX_LAST = INDEX_W'(BLOCK_DIM * BLOCK_DIM - 1);

    // loading stops only right after a pixel was taken
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(pix_ready) |-> $past(pix_valid))
        else $error("pixel ready dropped without an accepted pixel");

    // the block end marker sits on the final natural-order position
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && last_coef |-> coef_index == IDX_LAST)
        else $error("last_coef on wrong index");

    // within a block coefficients come in natural order
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && coef_ready && !last_coef |=>
            !coef_valid || coef_index == INDEX_W'($past(coef_index) + 1'b1))
        else $error("coefficient index skipped");

    // no loading while a block is still being emitted
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(coef_valid && !last_coef && pix_ready))
        else $error("pixel input open during coefficient output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && !coef_ready |=>
            coef_valid && $stable(coefficient) && $stable(coef_index))
        else $error("stalled coefficient word changed");

endmodule

bind forward_dct_8x8 dct_chk #(.BLOCK_DIM(BLOCK_DIM)) u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (pixels.valid),
    .pix_ready   (pixels.ready),
    .coef_valid  (coefs.valid),
    .coef_ready  (coefs.ready),
    .coefficient (coefs.coefficient),
    .coef_index  (coefs.coef_index),
    .last_coef   (coefs.last_coef)
);

`default_nettype wire

FILE: tb/forward_dct_8x8_tb.sv
`timescale 1ns / 1ps

module forward_dct_8x8_tb import dct_pkg::*; ();

    localparam int DIM          = DIM_DEFAULT;
    localparam int NPIX         = DIM * DIM;
    localparam int ANGLES       = 4 * DIM;
    // Longest correct stretch without any word moving is the long hold below
    // plus one coefficient interval; allow several times that.
    localparam int QUIET_MAX    = 20000;
    localparam int HOLD_CYCLES  = 3000;
    // Pipeline drain after the last expected word: six stages plus margin
    localparam int DRAIN_CYCLES = 100;

    localparam longint COEF_MAX = (longint'(1) <<< (COEF_W - 1)) - 1;
    localparam longint COEF_MIN = -(longint'(1) <<< (COEF_W - 1));

    typedef struct {
        logic signed [COEF_W-1:0] coefficient;
        logic [INDEX_W-1:0]       coef_index;
        logic                     last_coef;
    } coef_word_t;

    typedef enum int {FILL_UNIFORM, FILL_GRADIENT, FILL_BINARY, FILL_FLAT} fill_kind_t;

    logic clk;
    logic rst_n;

    dct_pix_if  pix_bus();
    dct_coef_if coef_bus();

    forward_dct_8x8 dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixels(pix_bus),
        .coefs (coef_bus)
    );

    // Predictor state: cosine samples, basis table, local pixel store
    real              cos_sample [ANGLES];
    int               basis_rom [NPIX][NPIX];
    logic [PIX_W-1:0] block_store [NPIX];
    int               pixels_loaded;
    coef_word_t       expected_coefs [$];

    // Content of the random block, built up front and sent in parts
    logic [PIX_W-1:0] next_block [NPIX];

    int errors;
    bit idle_on;
    bit hold_req;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Basis entry (i, j) = trunc(256 * cos(u(2k+1)pi/16) * cos(v(2l+1)pi/16)),
    // formed as trunc(128 * (cos(x+y) + cos(x-y))). Snap values a hair below
    // an integer up to it, so that exact cases such as 128 are not lost.
    function automatic void build_basis();
        real pi_val;
        real s;
        real mag;
        int  m;
        int  i;
        int  j;
        int  x;
        int  y;
        int  d;
        int  q;
        pi_val = 4.0 * $atan(1.0);
        for (m = 0; m < ANGLES; m++)
        begin
            cos_sample[m] = $cos(pi_val * m / (2.0 * DIM));
        end
        for (i = 0; i < NPIX; i++)
        begin
            for (j = 0; j < NPIX; j++)
            begin
                x   = (i / DIM) * (2 * (j / DIM) + 1);
                y   = (i % DIM) * (2 * (j % DIM) + 1);
                d   = (x > y) ? x - y : y - x;
                s   = 128.0 * (cos_sample[(x + y) % ANGLES] + cos_sample[d % ANGLES]);
                mag = (s < 0.0) ? -s : s;
                q   = int'($floor(mag + 2.0 ** (-30)));
                basis_rom[i][j] = (s < 0.0) ? -q : q;
            end
        end
    endfunction

    // 256 * c(u) * c(v): 32 for DC, 45 on the first row or column, else 64
    function automatic longint scale_for(int u, int v);
        int zeros;
        zeros = (u == 0) + (v == 0);
        if (zeros == 2)
        begin
            return 256 / DIM;
        end
        else if (zeros == 1)
        begin
            return 362 / DIM;
        end
        return 512 / DIM;
    endfunction

    // Weighted sum, scale, floor shift, clamp; queue all 64 words
    function automatic void predict_coefs();
        longint     acc;
        longint     c;
        int         i;
        int         j;
        coef_word_t word;
        for (i = 0; i < NPIX; i++)
        begin
            acc = 0;
            for (j = 0; j < NPIX; j++)
            begin
                acc += longint'(block_store[j]) * basis_rom[i][j];
            end
            acc = acc * scale_for(i / DIM, i % DIM);
            c   = acc >>> OUT_SHIFT;
            if (c > COEF_MAX)
            begin
                c = COEF_MAX;
            end
            if (c < COEF_MIN)
            begin
                c = COEF_MIN;
            end
            word.coefficient = c[COEF_W-1:0];
            word.coef_index  = i[INDEX_W-1:0];
            word.last_coef   = (i == NPIX - 1);
            expected_coefs.push_back(word);
        end
    endfunction

    function automatic void store_pixel(logic [PIX_W-1:0] value);
        block_store[pixels_loaded] = value;
        pixels_loaded++;
        if (pixels_loaded == NPIX)
        begin
            pixels_loaded = 0;
            predict_coefs();
        end
    endfunction

    // Offer one pixel word, maybe after a burst of idle cycles, and hold it
    // until the block takes it. Returns at the accepting edge.
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.pixel <= value;
        @(posedge clk);
        while (pix_bus.ready !== 1'b1) @(posedge clk);
        store_pixel(value);
    endtask

    // Random content; half of the blocks are smooth images with noise, the rest
    // are noise, flat fields or two-level pictures.
    function automatic void fill_random_block();
        fill_kind_t kind;
        int         base;
        int         slope_r;
        int         slope_c;
        int         noise;
        int         idx;
        int         val;
        case ($urandom_range(0, 5))
            0:       kind = FILL_UNIFORM;
            1:       kind = FILL_BINARY;
            2:       kind = FILL_FLAT;
            default: kind = FILL_GRADIENT;
        endcase
        base    = $urandom_range(0, 255);
        slope_r = int'($urandom_range(0, 64)) - 32;
        slope_c = int'($urandom_range(0, 64)) - 32;
        noise   = $urandom_range(0, 8);
        for (idx = 0; idx < NPIX; idx++)
        begin
            case (kind)
                FILL_UNIFORM:  val = $urandom_range(0, 255);
                FILL_BINARY:   val = $urandom_range(0, 1) ? 255 : 0;
                FILL_FLAT:     val = base;
                default:
                begin
                    val = base + slope_r * (idx / DIM) + slope_c * (idx % DIM)
                          + int'($urandom_range(0, 2 * noise)) - noise;
                end
            endcase
            if (val < 0)
            begin
                val = 0;
            end
            if (val > 255)
            begin
                val = 255;
            end
            next_block[idx] = val[PIX_W-1:0];
        end
    endfunction

    task automatic send_block_part(input int first, input int count);
        int idx;
        for (idx = first; idx < first + count; idx++)
        begin
            send_pixel(next_block[idx]);
        end
    endtask

    // Extremes: a 0/255 checkerboard puts full-scale pixels everywhere and
    // drives the highest frequency.
    task automatic test_directed_patterns();
        int idx;
        for (idx = 0; idx < NPIX; idx++)
        begin
            send_pixel((((idx / DIM) + (idx % DIM)) % 2 == 0) ? 8'd255 : 8'd0);
        end
    endtask

    // Ask the sink for a long hold, then keep offering the first half of a
    // random block: a coefficient parks in the output register, the MAC
    // freezes, and the new pixels wait at the input.
    task automatic test_output_backpressure();
        fill_random_block();
        hold_req = 1'b1;
        send_block_part(0, NPIX / 2);
    endtask

    // Drop all idling and finish the block flat out
    task automatic test_full_rate();
        idle_on = 1'b0;
        send_block_part(NPIX / 2, NPIX - NPIX / 2);
    endtask

    function automatic void check_coef();
        coef_word_t want;
        if (expected_coefs.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected word: expected none, got coefficient %0d index %0d last %0b",
                     $time, coef_bus.coefficient, coef_bus.coef_index, coef_bus.last_coef);
            return;
        end
        want = expected_coefs.pop_front();
        if (coef_bus.coefficient !== want.coefficient)
        begin
            errors++;
            $display("%0t: coefficient at index %0d: expected %0d, got %0d", $time,
                     want.coef_index, want.coefficient, coef_bus.coefficient);
        end
        if (coef_bus.coef_index !== want.coef_index)
        begin
            errors++;
            $display("%0t: coef_index: expected %0d, got %0d", $time,
                     want.coef_index, coef_bus.coef_index);
        end
        if (coef_bus.last_coef !== want.last_coef)
        begin
            errors++;
            $display("%0t: last_coef at index %0d: expected %0b, got %0b", $time,
                     want.coef_index, want.last_coef, coef_bus.last_coef);
        end
    endfunction

    // Sink: check each accepted word, then pick ready for the next edge.
    // A pending hold request wins over the random stall bursts.
    initial begin : coef_sink
        int   stall_left;
        int   hold_left;
        logic next_ready;
        stall_left     = 0;
        hold_left      = 0;
        coef_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && coef_bus.valid === 1'b1 && coef_bus.ready === 1'b1)
            begin
                check_coef();
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                hold_left  = HOLD_CYCLES - 1;
                next_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 16) - 1;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
            end
            coef_bus.ready <= next_ready;
        end
    end

    // Watchdog: end the run once nothing moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX)
        begin
            @(posedge clk);
            if ((pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1) ||
                (coef_bus.valid === 1'b1 && coef_bus.ready === 1'b1))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: timeout, %0d words still expected", $time, expected_coefs.size());
        $display("FAIL forward_dct_8x8");
        $finish;
    end

    initial begin : stimulus
        rst_n         = 1'b0;
        pix_bus.valid = 1'b0;
        pix_bus.pixel = '0;
        errors        = 0;
        pixels_loaded = 0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        build_basis();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_patterns();
        test_output_backpressure();
        test_full_rate();

        // Drop valid, wait out the queue, then give the pipeline time to
        // show any stray word.
        pix_bus.valid <= 1'b0;
        while (expected_coefs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("PASS forward_dct_8x8");
        end
        else
        begin
            $display("FAIL forward_dct_8x8");
        end
        $finish;
    end

endmodule
